### rtl/core/kcp_pkg.sv
// kcp_pkg: shared constants and link types for the k-closest-points selector.
// Used by kcp_front, kcp_cell and k_closest_points_select. No dependencies.

package kcp_pkg;

   localparam int KCP_COORD_BITS = 16;   // default coordinate width
   localparam int KCP_MAX_KEPT   = 16;   // default number of cells
   localparam int FIELD_BITS     = 16;   // port width of one coordinate
   localparam int DIST_OUT_BITS  = 32;   // port width of squared_distance
   localparam int CSR_BITS       = 5;    // width of k_count

   localparam logic [CSR_BITS-1:0] K_COUNT_RESET = CSR_BITS'(1);

   // one pipeline stage of the front end
   typedef struct packed {
      logic valid;
      logic last;
   } kcp_stage_type;

   // status one cell shows to its neighbors
   typedef struct packed {
      logic valid;   // cell holds a kept point
      logic ahead;   // new point ranks at or before this cell
   } kcp_link_type;

endpackage

### rtl/core/kcp_front.sv
// kcp_front: three-stage front end, coordinate magnitude, squares, sum.
// Depends on kcp_pkg.

module kcp_front import kcp_pkg::*; #(
   parameter int COORD_BITS = KCP_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_accept,
   input  logic [FIELD_BITS-1:0]     in_x,
   input  logic [FIELD_BITS-1:0]     in_y,
   input  logic                      in_last,
   output kcp_stage_type             out_stage,
   output logic [COORD_BITS-1:0]     out_x,
   output logic [COORD_BITS-1:0]     out_y,
   output logic [2*COORD_BITS-1:0]   out_d,
   output logic                      end_pending
);

   localparam int DIST_BITS = 2 * COORD_BITS;

   logic [COORD_BITS-1:0] x_c, y_c, mx_c, my_c;

   kcp_stage_type a_ff, a_in, b_ff, c_ff;
   logic [COORD_BITS-1:0] xa_ff, ya_ff, mxa_ff, mya_ff;
   logic [COORD_BITS-1:0] xb_ff, yb_ff;
   logic [DIST_BITS-1:0]  sqx_b_ff, sqy_b_ff;
   logic [COORD_BITS-1:0] xc_ff, yc_ff;
   logic [DIST_BITS-1:0]  dc_ff;

   // port value taken as a COORD_BITS two's complement number
   assign x_c  = COORD_BITS'(in_x);
   assign y_c  = COORD_BITS'(in_y);
   assign mx_c = x_c[COORD_BITS-1] ? COORD_BITS'(~x_c + 1'b1) : x_c;
   assign my_c = y_c[COORD_BITS-1] ? COORD_BITS'(~y_c + 1'b1) : y_c;

   assign a_in.valid = in_accept;
   assign a_in.last  = in_accept & in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= a_ff;
         c_ff <= b_ff;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff    <= x_c;
      ya_ff    <= y_c;
      mxa_ff   <= mx_c;
      mya_ff   <= my_c;
      xb_ff    <= xa_ff;
      yb_ff    <= ya_ff;
      sqx_b_ff <= DIST_BITS'(mxa_ff) * DIST_BITS'(mxa_ff);
      sqy_b_ff <= DIST_BITS'(mya_ff) * DIST_BITS'(mya_ff);
      xc_ff    <= xb_ff;
      yc_ff    <= yb_ff;
      dc_ff    <= sqx_b_ff + sqy_b_ff;   // at most 2^(DIST_BITS-1), no carry out
   end

   assign out_stage   = c_ff;
   assign out_x       = xc_ff;
   assign out_y       = yc_ff;
   assign out_d       = dc_ff;
   assign end_pending = a_ff.last | b_ff.last | c_ff.last;

endmodule

### rtl/core/kcp_cell.sv
// kcp_cell: one slot of the sorted insertion chain.
// Depends on kcp_pkg. Instantiated in a row by k_closest_points_select.

module kcp_cell import kcp_pkg::*; #(
   parameter int COORD_BITS = KCP_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      ins_en,      // new point enters the chain
   input  logic                      drain_shift, // head item taken, shift toward head
   input  logic                      in_range,    // slot index below effective k
   input  logic [COORD_BITS-1:0]     new_x,
   input  logic [COORD_BITS-1:0]     new_y,
   input  logic [2*COORD_BITS-1:0]   new_d,
   input  kcp_link_type              prev_link,
   input  logic [COORD_BITS-1:0]     prev_x,
   input  logic [COORD_BITS-1:0]     prev_y,
   input  logic [2*COORD_BITS-1:0]   prev_d,
   input  kcp_link_type              next_link,
   input  logic [COORD_BITS-1:0]     next_x,
   input  logic [COORD_BITS-1:0]     next_y,
   input  logic [2*COORD_BITS-1:0]   next_d,
   output kcp_link_type              link,
   output logic [COORD_BITS-1:0]     x,
   output logic [COORD_BITS-1:0]     y,
   output logic [2*COORD_BITS-1:0]   d
);

   localparam int DIST_BITS = 2 * COORD_BITS;

   logic                  valid_ff, valid_in, ahead;
   logic [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [DIST_BITS-1:0]  d_ff, d_in;

   // strict compare: an equal earlier point stays in front
   assign ahead = ~valid_ff | (d_ff > new_d);

   always_comb begin
      valid_in = valid_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      if (ins_en) begin
         if (!in_range) begin
            valid_in = 1'b0;
         end else if (prev_link.ahead) begin
            valid_in = prev_link.valid;
            x_in     = prev_x;
            y_in     = prev_y;
            d_in     = prev_d;
         end else if (ahead) begin
            valid_in = 1'b1;
            x_in     = new_x;
            y_in     = new_y;
            d_in     = new_d;
         end
      end else if (drain_shift) begin
         valid_in = next_link.valid;
         x_in     = next_x;
         y_in     = next_y;
         d_in     = next_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      d_ff <= d_in;
   end

   assign link.valid = valid_ff;
   assign link.ahead = ahead;
   assign x = x_ff;
   assign y = y_ff;
   assign d = d_ff;

endmodule

### rtl/core/k_closest_points_select.sv
// k_closest_points_select: keeps the k points nearest the origin in a cell chain.
// The set_end item passes front-end stages a, b and c; its insertion sets drain_ff,
// and rsp items are valid from then on. Throughput: 1 point per cycle in a set;
// after set_end the input stalls through the front-end stages and the chain drain.
// Reset (synchronous): clears cell valid bits, front-end stages, drain flag,
// and sets k_count to 1. No clearing pass; cell payload needs no reset.
// Depends on kcp_pkg, kcp_front, kcp_cell.

module k_closest_points_select import kcp_pkg::*; #(
   parameter int MAX_KEPT   = KCP_MAX_KEPT,
   parameter int COORD_BITS = KCP_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // point input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*FIELD_BITS-1:0]       req_tdata,  // point_x, point_y
   input  logic                          req_tlast,  // set_end
   // selected points
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*FIELD_BITS+DIST_OUT_BITS-1:0] rsp_tdata, // near_x, near_y, squared_distance
   output logic                          rsp_tlast,  // final_result
   // k_count register
   input  logic                          csr_wr_en,
   input  logic [CSR_BITS-1:0]           csr_wr_data
);

   localparam int DIST_BITS = 2 * COORD_BITS;
   localparam int KW = ($clog2(MAX_KEPT + 1) > CSR_BITS) ? $clog2(MAX_KEPT + 1) : CSR_BITS;

   // ---------------- configuration ----------------
   logic [CSR_BITS-1:0] k_count_ff, k_count_in;
   logic [KW-1:0]       k_ext, eff_k;

   assign k_count_in = csr_wr_en ? csr_wr_data : k_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff <= K_COUNT_RESET;
      end else begin
         k_count_ff <= k_count_in;
      end
   end

   // clamp to 1..MAX_KEPT
   assign k_ext = KW'(k_count_ff);
   always_comb begin
      priority if (k_ext == '0) begin
         eff_k = KW'(1);
      end else if (k_ext > KW'(MAX_KEPT)) begin
         eff_k = KW'(MAX_KEPT);
      end else begin
         eff_k = k_ext;
      end
   end

   // ---------------- front end ----------------
   logic                  req_accept, end_pending;
   kcp_stage_type         ins_stage;
   logic [COORD_BITS-1:0] ins_x, ins_y;
   logic [DIST_BITS-1:0]  ins_d;

   assign req_accept = req_tvalid & req_tready;

   kcp_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (req_accept),
      .in_x        (req_tdata[FIELD_BITS-1:0]),
      .in_y        (req_tdata[2*FIELD_BITS-1:FIELD_BITS]),
      .in_last     (req_tlast),
      .out_stage   (ins_stage),
      .out_x       (ins_x),
      .out_y       (ins_y),
      .out_d       (ins_d),
      .end_pending (end_pending)
   );

   // ---------------- drain control ----------------
   // drain_ff: the set is closed and the chain shifts out toward cell 0.
   logic drain_ff, drain_in, rsp_accept;

   assign rsp_accept = rsp_tvalid & rsp_tready;

   always_comb begin
      drain_in = drain_ff;
      if (ins_stage.valid && ins_stage.last) begin
         drain_in = 1'b1;
      end else if (rsp_accept && rsp_tlast) begin
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
      end else begin
         drain_ff <= drain_in;
      end
   end

   // no new point while a closed set is still in flight or draining
   assign req_tready = ~drain_ff & ~end_pending;

   // ---------------- cell chain ----------------
   // Slot s holds cell s-1; slots 0 and MAX_KEPT+1 are empty ends of the row.
   kcp_link_type          link_w [0:MAX_KEPT+1];
   logic [COORD_BITS-1:0] x_w    [0:MAX_KEPT+1];
   logic [COORD_BITS-1:0] y_w    [0:MAX_KEPT+1];
   logic [DIST_BITS-1:0]  d_w    [0:MAX_KEPT+1];

   assign link_w[0]          = '0;
   assign x_w[0]             = '0;
   assign y_w[0]             = '0;
   assign d_w[0]             = '0;
   assign link_w[MAX_KEPT+1] = '0;
   assign x_w[MAX_KEPT+1]    = '0;
   assign y_w[MAX_KEPT+1]    = '0;
   assign d_w[MAX_KEPT+1]    = '0;

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      logic in_range;
      assign in_range = KW'(i) < eff_k;

      kcp_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ins_en      (ins_stage.valid),
         .drain_shift (rsp_accept),
         .in_range    (in_range),
         .new_x       (ins_x),
         .new_y       (ins_y),
         .new_d       (ins_d),
         .prev_link   (link_w[i]),
         .prev_x      (x_w[i]),
         .prev_y      (y_w[i]),
         .prev_d      (d_w[i]),
         .next_link   (link_w[i+2]),
         .next_x      (x_w[i+2]),
         .next_y      (y_w[i+2]),
         .next_d      (d_w[i+2]),
         .link        (link_w[i+1]),
         .x           (x_w[i+1]),
         .y           (y_w[i+1]),
         .d           (d_w[i+1])
      );
   end

   // ---------------- result ----------------
   // Head cell is the output register; final item when cell 1 is empty.
   logic [DIST_OUT_BITS-1:0] head_dist;

   if (DIST_BITS > DIST_OUT_BITS) begin : g_sat
      assign head_dist = (d_w[1] > DIST_BITS'({DIST_OUT_BITS{1'b1}})) ?
                         {DIST_OUT_BITS{1'b1}} : d_w[1][DIST_OUT_BITS-1:0];
   end else begin : g_nosat
      assign head_dist = DIST_OUT_BITS'(d_w[1]);
   end

   assign rsp_tvalid = drain_ff & link_w[1].valid;
   assign rsp_tlast  = ~link_w[2].valid;
   assign rsp_tdata  = {head_dist, FIELD_BITS'(y_w[1]), FIELD_BITS'(x_w[1])};

   // ---------------- assertions ----------------
   // kept points always form a prefix of the chain
   for (genvar i = 0; i + 1 < MAX_KEPT; i++) begin : g_chk_prefix
      a_prefix: assert property (@(posedge clock) disable iff (reset)
         link_w[i+2].valid |-> link_w[i+1].valid)
         else $error("kept points not contiguous at cell %0d", i + 1);
   end

   // a closed set always has a head item while draining
   a_drain_head: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> link_w[1].valid)
      else $error("drain active with empty head cell");

   // closing point starts the drain on the next cycle
   a_drain_start: assert property (@(posedge clock) disable iff (reset)
      (ins_stage.valid && ins_stage.last) |=> drain_ff)
      else $error("set end inserted but drain not started");

   // final item taken ends the drain and leaves the chain empty
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_tlast) |=> (!drain_ff && !link_w[1].valid))
      else $error("chain not empty after final item");

endmodule
